// ===== hw/rtl/shallow_water_wave_speeds_assert.svh =====
// assertion helpers for the wave speed block, clocked on clk and held off during rst
`ifndef SHALLOW_WATER_WAVE_SPEEDS_ASSERT_SVH
`define SHALLOW_WATER_WAVE_SPEEDS_ASSERT_SVH

// consequence in the same cycle
`define SWW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the next cycle
`define SWW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sww_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sww_pkg;

  localparam int H_W = 31;
  localparam int V_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [H_W-1:0] H_MAX = {H_W{1'b1}};
  localparam logic [H_W-1:0] GRAVITY_RESET = 31'd642908;
  localparam logic [H_W-1:0] DRY_HEIGHT_RESET = 31'd66;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY    = 2'd0,
    CFG_DRY_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [H_W-1:0]        h_left;
    logic signed [V_W-1:0] u_left;
    logic [H_W-1:0]        h_right;
    logic signed [V_W-1:0] u_right;
  } in_t;

  typedef struct packed {
    logic signed [V_W-1:0] speed_left_minus;
    logic signed [V_W-1:0] speed_left_plus;
    logic signed [V_W-1:0] speed_right_minus;
    logic signed [V_W-1:0] speed_right_plus;
    logic signed [V_W-1:0] speed_face_minus;
    logic signed [V_W-1:0] speed_face_plus;
    logic [H_W-1:0]        left_vector_scale;
    logic [H_W-1:0]        right_vector_scale;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sww_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// one restoring divide step: brings in dividend bit K of num * 2^SH
module sww_div_cell #(
  parameter int SH = 32,
  parameter int QW = 63,
  parameter int K  = 0
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [sww_pkg::H_W-1:0] num_in,
  input  wire logic [sww_pkg::H_W-1:0] den_in,
  input  wire logic [sww_pkg::H_W-1:0] rem_in,
  input  wire logic [QW-1:0]           q_in,
  output logic      [sww_pkg::H_W-1:0] num_out,
  output logic      [sww_pkg::H_W-1:0] den_out,
  output logic      [sww_pkg::H_W-1:0] rem_out,
  output logic      [QW-1:0]           q_out
);

  logic                    nbit;
  logic [sww_pkg::H_W:0]   rem_s;
  logic [sww_pkg::H_W:0]   diff;
  logic                    fits;
  logic [sww_pkg::H_W-1:0] rem_next;

  generate
    if (K >= SH) begin : g_num_bit
      assign nbit = num_in[K-SH];
    end else begin : g_zero_bit
      assign nbit = 1'b0;
    end
  endgenerate

  always_comb begin
    rem_s = {rem_in, nbit};
    diff = rem_s - {1'b0, den_in};
    fits = (rem_s >= {1'b0, den_in});
    rem_next = fits ? diff[sww_pkg::H_W-1:0] : rem_s[sww_pkg::H_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= num_in;
      den_out <= den_in;
      rem_out <= rem_next;
      q_out <= {q_in[QW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sww_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// one digit of the bitwise integer square root, consumes x bits 2*STEP+1:2*STEP
module sww_sqrt_cell #(
  parameter int XW   = 64,
  parameter int STEP = 0
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [XW-1:0]       x_in,
  input  wire logic [XW/2-1:0]     res_in,
  input  wire logic [XW/2+1:0]     rem_in,
  output logic      [XW-1:0]       x_out,
  output logic      [XW/2-1:0]     res_out,
  output logic      [XW/2+1:0]     rem_out
);

  localparam int RW = XW / 2;

  logic [RW+3:0] rem_s;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          fits;
  logic [RW+1:0] rem_next;

  always_comb begin
    rem_s = {rem_in, x_in[2*STEP+1 -: 2]};
    trial = {2'b00, res_in, 2'b01};
    diff = rem_s - trial;
    fits = (rem_s >= trial);
    rem_next = fits ? diff[RW+1:0] : rem_s[RW+1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_in;
      res_out <= {res_in[RW-2:0], fits};
      rem_out <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/shallow_water_wave_speeds.sv =====
// Shallow-water wave speeds: for each left/right cell pair the block returns u -/+ sqrt(g*h)
// at both cells and at the averaged face, and the face eigenvector scales sqrt(h/g)/2 and
// sqrt(g/h) (zero when the face height is at or below dry_height). One item is taken per
// clock while the row is not held; each item passes the input register, 2*FRAC_BITS + 31
// divider cells of the bit-serial divider row, one root cell per root bit and the output
// register. When the output is stalled with a result waiting, the whole row holds. Write
// gravity and dry_height only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "shallow_water_wave_speeds_assert.svh"

module shallow_water_wave_speeds #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire sww_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output sww_pkg::out_t                      out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sww_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sww_pkg::H_W-1:0]       cfg_data
);

  localparam int HW   = sww_pkg::H_W;
  localparam int VW   = sww_pkg::V_W;
  localparam int SH   = 2 * FRAC_BITS;
  localparam int QW   = HW + SH;
  localparam int SQW  = (QW > 64) ? 64 : QW;
  localparam int SQWE = SQW + (SQW % 2);
  localparam int RW2  = SQWE / 2;
  localparam int SW   = (RW2 > HW) ? RW2 : HW;
  localparam int NST  = QW + RW2;
  localparam int PW   = 2 * HW;
  localparam int CRW  = HW;
  localparam int ULEN = CRW + 1;
  localparam int SPN  = NST - ULEN;

  typedef struct packed {
    logic signed [VW-1:0] ul;
    logic signed [VW-1:0] ur;
    logic signed [VW-1:0] uf;
  } u3_t;

  typedef struct packed {
    logic signed [VW-1:0] lm;
    logic signed [VW-1:0] lp;
    logic signed [VW-1:0] rm;
    logic signed [VW-1:0] rp;
    logic signed [VW-1:0] fm;
    logic signed [VW-1:0] fp;
  } sp_t;

  typedef struct packed {
    logic gz;
    logic hbig;
    logic ovf_l;
    logic ovf_r;
  } flg_t;

  function automatic logic signed [VW-1:0] sat_speed(logic signed [VW-1:0] u,
                                                      logic [CRW-1:0] c, logic sub);
    logic signed [VW+1:0] s;
    s = sub ? ({{2{u[VW-1]}}, u} - {3'b000, c}) : ({{2{u[VW-1]}}, u} + {3'b000, c});
    if (s > $signed({3'b000, {(VW-1){1'b1}}})) begin
      return {1'b0, {(VW-1){1'b1}}};
    end else if (s < $signed({3'b111, {(VW-1){1'b0}}})) begin
      return {1'b1, {(VW-1){1'b0}}};
    end else begin
      return s[VW-1:0];
    end
  endfunction

  function automatic logic [HW-1:0] sat_scale(logic [RW2-1:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    return (w > SW'(sww_pkg::H_MAX)) ? sww_pkg::H_MAX : w[HW-1:0];
  endfunction

  logic          en;
  logic [HW-1:0] gravity;
  logic [HW-1:0] dry_height;

  // input stage
  logic                 a_valid;
  logic [HW-1:0]        a_hl, a_hr, a_hf;
  logic signed [VW-1:0] a_ul, a_ur, a_uf;
  flg_t                 a_flg;
  logic [HW:0]          h_sum;
  logic signed [VW:0]   u_sum;

  // celerity path
  logic [PW-1:0]  prod [3];
  u3_t            uline [ULEN];
  logic [PW-1:0]  c_x   [3][CRW];
  logic [CRW-1:0] c_res [3][CRW];
  logic [CRW+1:0] c_rem [3][CRW];
  sp_t            spl   [SPN];

  // scale path
  logic [HW-1:0]  dl_num [QW], dl_den [QW], dl_rem [QW];
  logic [QW-1:0]  dl_q   [QW];
  logic [HW-1:0]  dr_num [QW], dr_den [QW], dr_rem [QW];
  logic [QW-1:0]  dr_q   [QW];
  logic [SQWE-1:0] sl_x [RW2], sr_x [RW2];
  logic [RW2-1:0]  sl_res [RW2], sr_res [RW2];
  logic [RW2+1:0]  sl_rem [RW2], sr_rem [RW2];

  logic [NST-1:0] vline;
  flg_t           fline [NST];
  logic           ovf_l, ovf_r;

  logic [HW-1:0]  left_scale, right_scale;

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= sww_pkg::GRAVITY_RESET;
      dry_height <= sww_pkg::DRY_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sww_pkg::CFG_GRAVITY:    gravity <= cfg_data;
        sww_pkg::CFG_DRY_HEIGHT: dry_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    h_sum = {1'b0, in_data.h_left} + {1'b0, in_data.h_right};
    u_sum = {in_data.u_left[VW-1], in_data.u_left} + {in_data.u_right[VW-1], in_data.u_right};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_hl <= in_data.h_left;
      a_hr <= in_data.h_right;
      a_hf <= h_sum[HW:1];
      a_ul <= in_data.u_left;
      a_ur <= in_data.u_right;
      a_uf <= u_sum[VW:1];
      a_flg.gz <= (gravity == '0);
      a_flg.hbig <= (h_sum[HW:1] > dry_height);
      a_flg.ovf_l <= 1'b0;
      a_flg.ovf_r <= 1'b0;
    end
  end

  // celerity: product register, then a row of root cells per lane
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= PW'(a_hl) * PW'(gravity);
      prod[1] <= PW'(a_hr) * PW'(gravity);
      prod[2] <= PW'(a_hf) * PW'(gravity);
      uline[0] <= '{ul: a_ul, ur: a_ur, uf: a_uf};
      for (int k = 1; k < ULEN; k++) begin
        uline[k] <= uline[k-1];
      end
    end
  end

  generate
    for (genvar m = 0; m < 3; m++) begin : g_lane
      for (genvar j = 0; j < CRW; j++) begin : g_cel
        if (j == 0) begin : g_first
          sww_sqrt_cell #(.XW(PW), .STEP(CRW-1-j)) u_cell (
            .clk(clk), .en(en),
            .x_in(prod[m]), .res_in('0), .rem_in('0),
            .x_out(c_x[m][j]), .res_out(c_res[m][j]), .rem_out(c_rem[m][j])
          );
        end else begin : g_next
          sww_sqrt_cell #(.XW(PW), .STEP(CRW-1-j)) u_cell (
            .clk(clk), .en(en),
            .x_in(c_x[m][j-1]), .res_in(c_res[m][j-1]), .rem_in(c_rem[m][j-1]),
            .x_out(c_x[m][j]), .res_out(c_res[m][j]), .rem_out(c_rem[m][j])
          );
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      spl[0].lm <= sat_speed(uline[ULEN-1].ul, c_res[0][CRW-1], 1'b1);
      spl[0].lp <= sat_speed(uline[ULEN-1].ul, c_res[0][CRW-1], 1'b0);
      spl[0].rm <= sat_speed(uline[ULEN-1].ur, c_res[1][CRW-1], 1'b1);
      spl[0].rp <= sat_speed(uline[ULEN-1].ur, c_res[1][CRW-1], 1'b0);
      spl[0].fm <= sat_speed(uline[ULEN-1].uf, c_res[2][CRW-1], 1'b1);
      spl[0].fp <= sat_speed(uline[ULEN-1].uf, c_res[2][CRW-1], 1'b0);
      for (int k = 1; k < SPN; k++) begin
        spl[k] <= spl[k-1];
      end
    end
  end

  // scales: h_face*2^SH/g on the left row, g*2^SH/h_face on the right row
  generate
    for (genvar j = 0; j < QW; j++) begin : g_div
      if (j == 0) begin : g_first
        sww_div_cell #(.SH(SH), .QW(QW), .K(QW-1-j)) u_left (
          .clk(clk), .en(en),
          .num_in(a_hf), .den_in(gravity), .rem_in('0), .q_in('0),
          .num_out(dl_num[j]), .den_out(dl_den[j]), .rem_out(dl_rem[j]), .q_out(dl_q[j])
        );
        sww_div_cell #(.SH(SH), .QW(QW), .K(QW-1-j)) u_right (
          .clk(clk), .en(en),
          .num_in(gravity), .den_in(a_hf), .rem_in('0), .q_in('0),
          .num_out(dr_num[j]), .den_out(dr_den[j]), .rem_out(dr_rem[j]), .q_out(dr_q[j])
        );
      end else begin : g_next
        sww_div_cell #(.SH(SH), .QW(QW), .K(QW-1-j)) u_left (
          .clk(clk), .en(en),
          .num_in(dl_num[j-1]), .den_in(dl_den[j-1]), .rem_in(dl_rem[j-1]),
          .q_in(dl_q[j-1]),
          .num_out(dl_num[j]), .den_out(dl_den[j]), .rem_out(dl_rem[j]), .q_out(dl_q[j])
        );
        sww_div_cell #(.SH(SH), .QW(QW), .K(QW-1-j)) u_right (
          .clk(clk), .en(en),
          .num_in(dr_num[j-1]), .den_in(dr_den[j-1]), .rem_in(dr_rem[j-1]),
          .q_in(dr_q[j-1]),
          .num_out(dr_num[j]), .den_out(dr_den[j]), .rem_out(dr_rem[j]), .q_out(dr_q[j])
        );
      end
    end

    if (QW > 64) begin : g_ovf
      assign ovf_l = |dl_q[QW-1][QW-1:64];
      assign ovf_r = |dr_q[QW-1][QW-1:64];
    end else begin : g_no_ovf
      assign ovf_l = 1'b0;
      assign ovf_r = 1'b0;
    end

    for (genvar j = 0; j < RW2; j++) begin : g_root
      if (j == 0) begin : g_first
        sww_sqrt_cell #(.XW(SQWE), .STEP(RW2-1-j)) u_left (
          .clk(clk), .en(en),
          .x_in(SQWE'(dl_q[QW-1][SQW-1:0])), .res_in('0), .rem_in('0),
          .x_out(sl_x[j]), .res_out(sl_res[j]), .rem_out(sl_rem[j])
        );
        sww_sqrt_cell #(.XW(SQWE), .STEP(RW2-1-j)) u_right (
          .clk(clk), .en(en),
          .x_in(SQWE'(dr_q[QW-1][SQW-1:0])), .res_in('0), .rem_in('0),
          .x_out(sr_x[j]), .res_out(sr_res[j]), .rem_out(sr_rem[j])
        );
      end else begin : g_next
        sww_sqrt_cell #(.XW(SQWE), .STEP(RW2-1-j)) u_left (
          .clk(clk), .en(en),
          .x_in(sl_x[j-1]), .res_in(sl_res[j-1]), .rem_in(sl_rem[j-1]),
          .x_out(sl_x[j]), .res_out(sl_res[j]), .rem_out(sl_rem[j])
        );
        sww_sqrt_cell #(.XW(SQWE), .STEP(RW2-1-j)) u_right (
          .clk(clk), .en(en),
          .x_in(sr_x[j-1]), .res_in(sr_res[j-1]), .rem_in(sr_rem[j-1]),
          .x_out(sr_x[j]), .res_out(sr_res[j]), .rem_out(sr_rem[j])
        );
      end
    end
  endgenerate

  // valid and flag lines run beside the divider and root rows
  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else if (en) begin
      vline <= {vline[NST-2:0], a_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fline[0] <= a_flg;
      for (int k = 1; k < NST; k++) begin
        if (k == QW) begin
          // overflow is known once the last quotient bit is out
          fline[k] <= '{gz: fline[k-1].gz, hbig: fline[k-1].hbig, ovf_l: ovf_l, ovf_r: ovf_r};
        end else begin
          fline[k] <= fline[k-1];
        end
      end
    end
  end

  always_comb begin
    left_scale = (fline[NST-1].gz || fline[NST-1].ovf_l) ? sww_pkg::H_MAX :
                 sat_scale(sl_res[RW2-1] >> 1);
    right_scale = !fline[NST-1].hbig ? '0 :
                  fline[NST-1].ovf_r ? sww_pkg::H_MAX : sat_scale(sr_res[RW2-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vline[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.speed_left_minus <= spl[SPN-1].lm;
      out_data.speed_left_plus <= spl[SPN-1].lp;
      out_data.speed_right_minus <= spl[SPN-1].rm;
      out_data.speed_right_plus <= spl[SPN-1].rp;
      out_data.speed_face_minus <= spl[SPN-1].fm;
      out_data.speed_face_plus <= spl[SPN-1].fp;
      out_data.left_vector_scale <= left_scale;
      out_data.right_vector_scale <= right_scale;
    end
  end

  `SWW_ASSERT_SAME(a_hold_input_when_blocked, out_valid && out_stall, in_stall, "input taken while output blocked")
  `SWW_ASSERT_SAME(a_face_speed_order, out_valid, out_data.speed_face_plus >= out_data.speed_face_minus, "face speeds out of order")
  `SWW_ASSERT_NEXT(a_pipe_reaches_output, en && vline[NST-1], out_valid, "result lost at output register")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY = 96;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  sww_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  sww_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [sww_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sww_pkg::H_W-1:0] cfg_data;

  int mismatches = 0;

  shallow_water_wave_speeds #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  task automatic report(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  // floor(sqrt(x)) for any 64-bit value
  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // scale from floor(num * 2^2F / den); saturates when den is zero or quotient >= 2^64
  function automatic logic [30:0] scaled_root(input logic [30:0] num, input logic [30:0] den,
                                              input bit halve);
    logic [127:0] q;
    logic [63:0] s;
    if (den == 0) return sww_pkg::H_MAX;
    q = ({97'd0, num} << (2 * FRAC_BITS)) / den;
    if (q[127:64] != 0) return sww_pkg::H_MAX;
    s = root_floor(q[63:0]);
    if (halve) s >>= 1;
    if (s > 64'h7fffffff) return sww_pkg::H_MAX;
    return s[30:0];
  endfunction

  class wave_scoreboard;
    logic [30:0] gravity;
    logic [30:0] dry_height;
    sww_pkg::out_t pending[$];

    function new();
      gravity = sww_pkg::GRAVITY_RESET;
      dry_height = sww_pkg::DRY_HEIGHT_RESET;
    endfunction

    function logic [63:0] celerity(input logic [30:0] h);
      return root_floor({33'd0, gravity} * {33'd0, h});
    endfunction

    function void note_face(input sww_pkg::in_t it);
      sww_pkg::out_t r;
      logic [30:0] hf;
      logic signed [32:0] usum;
      logic signed [31:0] uf;
      logic signed [65:0] c;
      hf = ({1'b0, it.h_left} + {1'b0, it.h_right}) >> 1;
      usum = it.u_left + it.u_right;
      uf = usum >>> 1;
      c = $signed({2'b0, celerity(it.h_left)});
      r.speed_left_minus = clamp32(it.u_left - c);
      r.speed_left_plus = clamp32(it.u_left + c);
      c = $signed({2'b0, celerity(it.h_right)});
      r.speed_right_minus = clamp32(it.u_right - c);
      r.speed_right_plus = clamp32(it.u_right + c);
      c = $signed({2'b0, celerity(hf)});
      r.speed_face_minus = clamp32(uf - c);
      r.speed_face_plus = clamp32(uf + c);
      r.left_vector_scale = scaled_root(hf, gravity, 1);
      r.right_vector_scale = (hf > dry_height) ? scaled_root(gravity, hf, 0) : '0;
      pending.push_back(r);
    endfunction

    task check_result(input sww_pkg::out_t got);
      sww_pkg::out_t e;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.speed_left_minus !== e.speed_left_minus) report("speed_left_minus");
      if (got.speed_left_plus !== e.speed_left_plus) report("speed_left_plus");
      if (got.speed_right_minus !== e.speed_right_minus) report("speed_right_minus");
      if (got.speed_right_plus !== e.speed_right_plus) report("speed_right_plus");
      if (got.speed_face_minus !== e.speed_face_minus) report("speed_face_minus");
      if (got.speed_face_plus !== e.speed_face_plus) report("speed_face_plus");
      if (got.left_vector_scale !== e.left_vector_scale) report("left_vector_scale");
      if (got.right_vector_scale !== e.right_vector_scale) report("right_vector_scale");
    endtask
  endclass

  wave_scoreboard faces = new();
  sww_pkg::in_t directed[$];
  int burst_left = 0;
  bit stall_mode = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) faces.note_face(in_data);
      if (out_valid && !out_stall) faces.check_result(out_data);
    end
  end

  // receiver stall pattern: calm stretches and heavy-stall stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b0;
  end

  task automatic write_reg(input sww_pkg::cfg_reg_t idx, input logic [30:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    faces.gravity = (idx == sww_pkg::CFG_GRAVITY) ? val : faces.gravity;
    faces.dry_height = (idx == sww_pkg::CFG_DRY_HEIGHT) ? val : faces.dry_height;
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (faces.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // transfer one item, with burst-and-gap idling in front of it
  task automatic send_face(input sww_pkg::in_t it);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [30:0] rand_height();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(0, 4));
      1: return sww_pkg::H_MAX - 31'($urandom_range(0, 4));
      2: return 31'($urandom) >> $urandom_range(0, 30);
      default: return 31'($urandom_range(0, 32'h00ff_ffff));
    endcase
  endfunction

  function automatic logic [31:0] rand_speed();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return $urandom;
      default: return 32'($signed(21'($urandom)));
    endcase
  endfunction

  task automatic random_faces(input int n);
    sww_pkg::in_t it;
    repeat (n) begin
      it.h_left = rand_height();
      it.u_left = rand_speed();
      it.h_right = $urandom_range(0, 3) == 0 ? it.h_left : rand_height();
      it.u_right = rand_speed();
      send_face(it);
    end
    in_valid <= 0;
  endtask

  initial begin
    sww_pkg::in_t it;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = sww_pkg::CFG_GRAVITY;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, face height near dry_height, odd velocity sums
    directed.push_back('{31'd0, 32'sd0, 31'd0, 32'sd0});
    directed.push_back('{sww_pkg::H_MAX, 32'sh7fffffff, sww_pkg::H_MAX, 32'sh7fffffff});
    directed.push_back('{sww_pkg::H_MAX, 32'sh80000000, sww_pkg::H_MAX, 32'sh80000000});
    directed.push_back('{31'd0, 32'sh80000000, sww_pkg::H_MAX, 32'sh7fffffff});
    directed.push_back('{sww_pkg::H_MAX, -32'sd1, 31'd0, 32'sd0});
    directed.push_back('{31'd66, 32'sd1, 31'd66, 32'sd0});
    directed.push_back('{31'd67, -32'sd1, 31'd67, -32'sd2});
    directed.push_back('{31'd66, 32'sd3, 31'd67, -32'sd4});
    directed.push_back('{31'd1, 32'sd0, 31'd0, -32'sd1});
    directed.push_back('{31'h10000, 32'sh10000, 31'h10000, -32'sh10000});
    directed.push_back('{31'h55555555, 32'sh55555555, 31'h2aaaaaaa, 32'shaaaaaaaa});
    directed.push_back('{31'h2aaaaaaa, 32'shaaaaaaaa, 31'h55555555, 32'sh55555555});
    foreach (directed[i]) send_face(directed[i]);
    in_valid <= 0;
    random_faces(250);

    // pause until everything is back, then run new register settings
    drain();
    write_reg(sww_pkg::CFG_GRAVITY, 31'd1);
    write_reg(sww_pkg::CFG_DRY_HEIGHT, 31'd0);
    foreach (directed[i]) send_face(directed[i]);
    in_valid <= 0;
    random_faces(200);

    drain();
    write_reg(sww_pkg::CFG_GRAVITY, sww_pkg::H_MAX);
    write_reg(sww_pkg::CFG_DRY_HEIGHT, sww_pkg::H_MAX);
    random_faces(200);

    drain();
    write_reg(sww_pkg::CFG_GRAVITY, 31'($urandom));
    write_reg(sww_pkg::CFG_DRY_HEIGHT, 31'($urandom_range(0, 32'hffff)));
    random_faces(200);

    drain();
    write_reg(sww_pkg::CFG_GRAVITY, sww_pkg::GRAVITY_RESET);
    write_reg(sww_pkg::CFG_DRY_HEIGHT, 31'h10000);
    random_faces(200);

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sww_pkg.sv
hw/rtl/sww_div_cell.sv
hw/rtl/sww_sqrt_cell.sv
hw/rtl/shallow_water_wave_speeds.sv
tb/sv/testbench.sv
